// ===== sv/pni_pkg.sv =====
// Package for the pose blend unit: payload structs, datapath command codes,
// and fixed-point helpers. No dependencies.
`timescale 1ns / 1ps

package pni_pkg;

    // Saturation width of results, clamped to the 16..32 range
    localparam int VALUE_WIDTH = 32;
    localparam int SAT_WIDTH   = (VALUE_WIDTH < 16) ? 16 : ((VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH);

    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [31:0] ONE_Q30 = 32'd1073741824;

    // Component codes
    localparam logic [2:0] COMP_TZ = 3'd2;
    localparam logic [2:0] COMP_RW = 3'd3;
    localparam logic [2:0] COMP_RZ = 3'd6;
    localparam logic [2:0] COMP_NONE = 3'd7;

    typedef struct packed {
        logic [2:0]         component;
        logic signed [31:0] from_value;
        logic signed [31:0] to_value;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]         out_component;
        logic signed [31:0] blended_value;
        logic               last;
        logic               degenerate;
    } out_beat_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_TR_MUL0,
        OP_TR_MUL1,
        OP_TR_EMIT,
        OP_DOT_STEP,
        OP_BL_MUL0,
        OP_BL_MUL1,
        OP_BL_WR,
        OP_SQ_STEP,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_EMIT_Q,
        OP_EMIT_DEGEN
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic len_zero;
        logic out_free;
    } dp_status_t;

    // Clip to the signed SAT_WIDTH range
    function automatic logic [31:0] sat_val(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        logic signed [63:0] c;
        hi = (64'sd1 <<< (SAT_WIDTH - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
            c = hi;
        else if (v < lo)
            c = lo;
        else
            c = v;
        return c[31:0];
    endfunction

    // Divide by 2^16, round to nearest, ties away from zero
    function automatic logic signed [63:0] round_q16(input logic signed [63:0] x);
        logic [63:0] mag;
        logic [63:0] q;
        mag = x[63] ? (64'd0 - x) : x;
        q   = (mag + 64'd32768) >> 16;
        return x[63] ? (64'sd0 - $signed(q)) : $signed(q);
    endfunction

endpackage

// ===== sv/pni_datapath.sv =====
// Datapath of the pose blend unit: shared multiplier, accumulator, rotation
// slots, square-root and divider iterations, output register. Uses pni_pkg.
`timescale 1ns / 1ps

module pni_datapath
    import pni_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,
    input  in_beat_t    in_data,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic        out_stall,
    output logic        out_valid,
    output out_beat_t   out_data
);

    logic [16:0]        t_reg;
    logic [16:0]        t_c;
    logic [17:0]        omt;
    logic signed [31:0] a_reg, b_reg;
    logic [2:0]         comp_reg;
    logic signed [31:0] s_reg [4];
    logic signed [31:0] e_reg [4];
    logic signed [33:0] r_reg [4];
    logic               neg_reg;
    logic signed [65:0] acc_reg;
    logic [64:0]        sum_reg;
    logic [63:0]        rad_reg;
    logic [33:0]        sqrem_reg;
    logic [31:0]        root_reg;
    logic [62:0]        num_reg;
    logic [31:0]        rem_reg;
    logic               qneg_reg;
    logic               out_valid_reg;
    out_beat_t          out_reg;

    logic signed [33:0] mul_x, mul_y;
    logic signed [67:0] prod;
    logic signed [33:0] e_ext, bt;
    logic [1:0]         slot;
    logic               load;
    out_beat_t          beat;

    // Clamped blend factor and its complement
    assign t_c = (t_reg > ONE_Q16) ? ONE_Q16 : t_reg;
    assign omt = {1'b0, ONE_Q16} - {1'b0, t_c};

    assign e_ext = {{2{e_reg[cmd.idx][31]}}, e_reg[cmd.idx]};
    assign bt    = neg_reg ? (34'sd0 - e_ext) : e_ext;
    assign slot  = 2'(in_data.component - COMP_RW);

    // Shared multiplier operand select
    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        unique case (cmd.op)
            OP_TR_MUL0:
            begin
                mul_x = {{2{a_reg[31]}}, a_reg};
                mul_y = {16'd0, omt};
            end
            OP_TR_MUL1:
            begin
                mul_x = {{2{b_reg[31]}}, b_reg};
                mul_y = {17'd0, t_c};
            end
            OP_DOT_STEP:
            begin
                mul_x = {{2{s_reg[cmd.idx][31]}}, s_reg[cmd.idx]};
                mul_y = e_ext;
            end
            OP_BL_MUL0:
            begin
                mul_x = {{2{s_reg[cmd.idx][31]}}, s_reg[cmd.idx]};
                mul_y = {16'd0, omt};
            end
            OP_BL_MUL1:
            begin
                mul_x = bt;
                mul_y = {17'd0, t_c};
            end
            OP_SQ_STEP:
            begin
                mul_x = r_reg[cmd.idx];
                mul_y = r_reg[cmd.idx];
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign prod = mul_x * mul_y;

    // Result beat assembly
    always_comb
    begin
        logic [63:0] qv;
        logic signed [63:0] v;
        qv   = {1'b0, num_reg};
        v    = qneg_reg ? (64'sd0 - $signed(qv)) : $signed(qv);
        beat = '0;
        load = 1'b0;
        unique case (cmd.op)
            OP_TR_EMIT:
            begin
                load                = 1'b1;
                beat.out_component  = comp_reg;
                beat.blended_value  = sat_val(round_q16(acc_reg[63:0]));
                beat.last           = 1'b1;
            end
            OP_EMIT_Q:
            begin
                load                = 1'b1;
                beat.out_component  = 3'(COMP_RW + 3'(cmd.idx));
                beat.blended_value  = sat_val(v);
                beat.last           = (cmd.idx == 2'd3);
            end
            OP_EMIT_DEGEN:
            begin
                load                = 1'b1;
                beat.out_component  = 3'(COMP_RW + 3'(cmd.idx));
                beat.blended_value  = (cmd.idx == 2'd0) ? sat_val({32'd0, ONE_Q30}) : 32'd0;
                beat.last           = (cmd.idx == 2'd3);
                beat.degenerate     = 1'b1;
            end
            default:
            begin
                load = 1'b0;
                beat = '0;
            end
        endcase
    end

    // Config register and rotation slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                s_reg[i] <= '0;
                e_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
                t_reg <= cfg_wr_data;
            if (cmd.op == OP_LOAD && in_data.component >= COMP_RW
                && in_data.component <= COMP_RZ)
            begin
                s_reg[slot] <= in_data.from_value;
                e_reg[slot] <= in_data.to_value;
            end
        end
    end

    // Arithmetic registers
    always_ff @(posedge clk)
    begin
        logic [35:0] srem_n;
        logic [35:0] trial;
        logic [32:0] drem_n;
        logic [33:0] mag;
        srem_n = {sqrem_reg, rad_reg[63:62]};
        trial  = {2'b00, root_reg, 2'b01};
        drem_n = {rem_reg, num_reg[62]};
        mag    = r_reg[cmd.idx][33] ? (34'd0 - r_reg[cmd.idx]) : r_reg[cmd.idx];
        unique case (cmd.op)
            OP_LOAD:
            begin
                a_reg    <= in_data.from_value;
                b_reg    <= in_data.to_value;
                comp_reg <= in_data.component;
            end
            OP_TR_MUL0: acc_reg <= prod[65:0];
            OP_TR_MUL1: acc_reg <= acc_reg + prod[65:0];
            OP_DOT_STEP:
                acc_reg <= ((cmd.idx == 2'd0) ? 66'sd0 : acc_reg) + prod[65:0];
            OP_BL_MUL0:
            begin
                if (cmd.idx == 2'd0)
                    neg_reg <= acc_reg[65];
                acc_reg <= prod[65:0];
            end
            OP_BL_MUL1: acc_reg <= acc_reg + prod[65:0];
            OP_BL_WR:   r_reg[cmd.idx] <= 34'(round_q16(acc_reg[63:0]));
            OP_SQ_STEP:
                sum_reg <= ((cmd.idx == 2'd0) ? 65'd0 : sum_reg) + {1'b0, prod[63:0]};
            OP_SQRT_INIT:
            begin
                rad_reg   <= sum_reg[64] ? {64{1'b1}} : sum_reg[63:0];
                sqrem_reg <= '0;
                root_reg  <= '0;
            end
            OP_SQRT_STEP:
            begin
                if (srem_n >= trial)
                begin
                    sqrem_reg <= 34'(srem_n - trial);
                    root_reg  <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    sqrem_reg <= srem_n[33:0];
                    root_reg  <= {root_reg[30:0], 1'b0};
                end
                rad_reg <= {rad_reg[61:0], 2'b00};
            end
            OP_DIV_INIT:
            begin
                num_reg  <= {mag[32:0], 30'd0} + {32'd0, root_reg[31:1]};
                rem_reg  <= '0;
                qneg_reg <= r_reg[cmd.idx][33];
            end
            OP_DIV_STEP:
            begin
                if (drem_n >= {1'b0, root_reg})
                begin
                    rem_reg <= 32'(drem_n - {1'b0, root_reg});
                    num_reg <= {num_reg[61:0], 1'b1};
                end
                else
                begin
                    rem_reg <= drem_n[31:0];
                    num_reg <= {num_reg[61:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= beat;
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;
    assign status.out_free = !out_valid_reg || !out_stall;
    assign status.len_zero = (root_reg == 32'd0);

endmodule

// ===== sv/pni_ctrl.sv =====
// Controller of the pose blend unit: sequences the datapath through blend,
// dot product, square root and division steps. Uses pni_pkg.
`timescale 1ns / 1ps

module pni_ctrl
    import pni_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [2:0] in_component,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_TR0, S_TR1, S_TROUT, S_DOT, S_BL0, S_BL1, S_BLW,
        S_SQ, S_SQI, S_SQRT, S_CHK, S_DVI, S_DV, S_DVOUT, S_DGOUT
    } state_t;

    state_t     state_reg;
    logic [1:0] idx_reg;
    logic [5:0] cnt_reg;
    logic       accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    // Command decode
    always_comb
    begin
        cmd.idx = idx_reg;
        unique case (state_reg)
            S_IDLE:  cmd.op = accept ? OP_LOAD : OP_NONE;
            S_TR0:   cmd.op = OP_TR_MUL0;
            S_TR1:   cmd.op = OP_TR_MUL1;
            S_TROUT: cmd.op = status.out_free ? OP_TR_EMIT : OP_NONE;
            S_DOT:   cmd.op = OP_DOT_STEP;
            S_BL0:   cmd.op = OP_BL_MUL0;
            S_BL1:   cmd.op = OP_BL_MUL1;
            S_BLW:   cmd.op = OP_BL_WR;
            S_SQ:    cmd.op = OP_SQ_STEP;
            S_SQI:   cmd.op = OP_SQRT_INIT;
            S_SQRT:  cmd.op = OP_SQRT_STEP;
            S_CHK:   cmd.op = OP_NONE;
            S_DVI:   cmd.op = OP_DIV_INIT;
            S_DV:    cmd.op = OP_DIV_STEP;
            S_DVOUT: cmd.op = status.out_free ? OP_EMIT_Q : OP_NONE;
            S_DGOUT: cmd.op = status.out_free ? OP_EMIT_DEGEN : OP_NONE;
            default: cmd.op = OP_NONE;
        endcase
    end

    // State, index and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (accept && in_component <= COMP_TZ)
                        state_reg <= S_TR0;
                    else if (accept && in_component == COMP_RZ)
                        state_reg <= S_DOT;
                end
                S_TR0:   state_reg <= S_TR1;
                S_TR1:   state_reg <= S_TROUT;
                S_TROUT:
                    if (status.out_free)
                        state_reg <= S_IDLE;
                S_DOT:
                begin
                    idx_reg <= idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                        state_reg <= S_BL0;
                end
                S_BL0:   state_reg <= S_BL1;
                S_BL1:   state_reg <= S_BLW;
                S_BLW:
                begin
                    idx_reg   <= idx_reg + 2'd1;
                    state_reg <= (idx_reg == 2'd3) ? S_SQ : S_BL0;
                end
                S_SQ:
                begin
                    idx_reg <= idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                        state_reg <= S_SQI;
                end
                S_SQI:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_SQRT;
                end
                // one root bit per cycle
                S_SQRT:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31)
                        state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    idx_reg   <= '0;
                    state_reg <= status.len_zero ? S_DGOUT : S_DVI;
                end
                S_DVI:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DV;
                end
                // one quotient bit per cycle, 63 bits
                S_DV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd62)
                        state_reg <= S_DVOUT;
                end
                S_DVOUT:
                    if (status.out_free)
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= (idx_reg == 2'd3) ? S_IDLE : S_DVI;
                    end
                S_DGOUT:
                    if (status.out_free)
                    begin
                        idx_reg <= idx_reg + 2'd1;
                        if (idx_reg == 2'd3)
                            state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/pose_nlerp_interpolator_unit.sv =====
// Top level of the pose blend unit: controller plus datapath.
// Depends on pni_pkg, pni_ctrl and pni_datapath.
`timescale 1ns / 1ps

// Blends two poses by the factor in the config register (Q1.16, clamped to
// 1.0). One component pair per beat. Translation beats (components 0..2)
// return one result from the shared multiplier, held while the output is
// not free. Rotation beats 3..5 are stored in their slot. Component 6 is
// stored too and runs the quaternion step: a dot product, a blend of the
// four slots through the single shared multiplier, a sum of squares, a
// bit-serial square root with one setup and one check state, then four
// restoring divisions, one result emitted after each; no new beat is
// taken until the step ends. Zero length skips the divisions and returns
// the identity with the degenerate flag. Component 7 is dropped.

module pose_nlerp_interpolator_unit
    import pni_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_beat_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_beat_t   out_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    pni_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_component (in_data.component),
        .in_stall     (in_stall),
        .status       (status),
        .cmd          (cmd)
    );

    pni_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .cmd         (cmd),
        .status      (status),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_data    (out_data)
    );

endmodule
